[rtl/bbps_pkg.sv]
package bbps_pkg;

  localparam int IMG_COLS_DEF  = 128;
  localparam int IMG_ROWS_DEF  = 128;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [7:0] DIM_RESET = 8'd128;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SQ    = 6'b000010,
    S_CUBE  = 6'b000100,
    S_WGT   = 6'b001000,
    S_RUN   = 6'b010000,
    S_DRAIN = 6'b100000
  } state_t;

  // weight set along one axis
  typedef enum logic [1:0] {
    WM_ONE = 2'd0,
    WM_LIN = 2'd1,
    WM_CUB = 2'd2
  } wmode_t;

  // rounding offset and final shift
  typedef enum logic [2:0] {
    RS_CORNER = 3'd0,
    RS_LIN    = 3'd1,
    RS_BIL    = 3'd2,
    RS_CUB1   = 3'd3,
    RS_CUB2   = 3'd4
  } rsel_t;

endpackage

[rtl/bicubic_border_pixel_sampler_unit.sv]
// Bicubic border pixel sampler.
// Command channel: an item is taken at a rising edge with start high and busy
// low. operation selects a pixel write (pixel_column, pixel_row, pixel_value)
// or a sample at the signed fixed-point position x_pos, y_pos.
// A write beat lands in the image memory at that edge and leaves busy low, so
// the next command may follow in the very next cycle; it returns no result.
// A sample beat raises busy and yields one result: done pulses high for exactly
// one cycle with sample_value valid, and busy falls in that same cycle. There
// is no back-pressure; the receiver must take the beat when done is high.
// A sample reads N image taps, where N is 16 for the interior bicubic, 4 for
// bilinear or the edge cubic, 2 for edge linear and 1 for a corner. The
// single-port image memory is read one tap a cycle, after weight setup in
// S_SQ, S_CUBE and S_WGT; each tap then passes the weight product, pixel
// product and accumulate registers, and S_DRAIN registers the rounded
// result once that tail is empty.
// Configuration: cfg_write with cfg_index 0 (image_width) or 1 (image_height)
// writes cfg_data; the user must do so only while the block is idle, and the
// block does not enforce this. Width in use clamps to 4..IMG_COLS, height
// to 4..IMG_ROWS. Sync rst: idle, dims 128; memory undefined till written.
module bicubic_border_pixel_sampler_unit #(
  parameter int IMG_COLS  = bbps_pkg::IMG_COLS_DEF,
  parameter int IMG_ROWS  = bbps_pkg::IMG_ROWS_DEF,
  parameter int FRAC_BITS = bbps_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic signed [19:0] x_pos,
  input  logic signed [19:0] y_pos,
  input  logic        [6:0]  pixel_column,
  input  logic        [6:0]  pixel_row,
  input  logic        [7:0]  pixel_value,
  output logic               done,
  output logic        [7:0]  sample_value,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic        [7:0]  cfg_data
);
  import bbps_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int MAXD = (IMG_COLS > IMG_ROWS) ? IMG_COLS : IMG_ROWS;
  localparam int DW0  = $clog2(MAXD + 1);
  localparam int DIMW = (DW0 > 8) ? DW0 : 8;
  localparam int PSW0 = DIMW + F + 2;
  localparam int PSW  = (PSW0 > 21) ? PSW0 : 21;
  localparam int RX   = $clog2(IMG_ROWS) + 1;
  localparam int CX   = $clog2(IMG_COLS) + 1;
  localparam int DEPTH = IMG_COLS * IMG_ROWS;
  localparam int MAW  = $clog2(DEPTH);
  localparam int WW   = 3 * F + 3;
  localparam int PW   = 2 * WW;
  localparam int PRW  = PW + 9;
  localparam int ACW  = PRW + 4;

  // image memory, single port
  logic [7:0]     mem [DEPTH];
  logic [MAW-1:0] mem_addr;
  logic           mem_we;
  logic [7:0]     mem_rdata;

  logic [7:0] image_width;
  logic [7:0] image_height;

  state_t state;

  // captured sample plan
  wmode_t         ymode, xmode;
  rsel_t          rsel;
  logic [RX-1:0]  r0, hlast;
  logic [CX-1:0]  c0, wlast;
  logic [F-1:0]   fa, fb;
  logic [2*F-1:0] a2y, a2x;
  logic [3*F-1:0] a3y, a3x;
  logic signed [WW-1:0] yw [4];
  logic signed [WW-1:0] xw [4];
  logic [1:0] tl, tk, nl, nk;

  logic                  v0, v1;
  logic signed [PW-1:0]  wprod;
  logic signed [PRW-1:0] prod;
  logic signed [ACW-1:0] acc;

  // decode of the incoming position
  logic [DIMW-1:0]        wd, hd;
  logic signed [PSW-1:0]  xs, ys, xmax, ymax, one_s, xcub, ycub, xi, yi;
  logic                   xneg, xbig, yneg, ybig, xin_c, yin_c;
  wmode_t                 d_ymode, d_xmode;
  rsel_t                  d_rsel;
  logic [RX-1:0]          d_r0, d_hlast;
  logic [CX-1:0]          d_c0, d_wlast;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  always_comb begin
    wd = DIMW'(image_width);
    hd = DIMW'(image_height);
    if (wd < DIMW'(4)) wd = DIMW'(4);
    else if (32'(wd) > IMG_COLS) wd = DIMW'(IMG_COLS);
    if (hd < DIMW'(4)) hd = DIMW'(4);
    else if (32'(hd) > IMG_ROWS) hd = DIMW'(IMG_ROWS);
    xs    = PSW'(x_pos);
    ys    = PSW'(y_pos);
    one_s = PSW'(1) <<< F;
    xmax  = PSW'(wd - DIMW'(1)) <<< F;
    ymax  = PSW'(hd - DIMW'(1)) <<< F;
    xcub  = PSW'(wd - DIMW'(2)) <<< F;
    ycub  = PSW'(hd - DIMW'(2)) <<< F;
    xi    = xs >>> F;
    yi    = ys >>> F;
    xneg  = xs < 0;
    yneg  = ys < 0;
    xbig  = xs > xmax;
    ybig  = ys > ymax;
    xin_c = (xs > one_s) && (xs < xcub);
    yin_c = (ys > one_s) && (ys < ycub);
    d_hlast = RX'(hd - DIMW'(1));
    d_wlast = CX'(wd - DIMW'(1));
    d_r0 = RX'(yi);
    d_c0 = CX'(xi);
    d_ymode = WM_LIN;
    d_xmode = WM_LIN;
    d_rsel  = RS_BIL;
    priority if ((xneg || xbig) && (yneg || ybig)) begin
      // corner: return that corner pixel
      d_ymode = WM_ONE;
      d_xmode = WM_ONE;
      d_rsel  = RS_CORNER;
      d_r0 = yneg ? RX'(0) : d_hlast;
      d_c0 = xneg ? CX'(0) : d_wlast;
    end else if (xneg || xbig) begin
      // run along the left or right column
      d_xmode = WM_ONE;
      d_c0    = xneg ? CX'(0) : d_wlast;
      d_ymode = yin_c ? WM_CUB : WM_LIN;
      d_rsel  = yin_c ? RS_CUB1 : RS_LIN;
      if (yin_c) d_r0 = RX'(yi) - RX'(1);
    end else if (yneg || ybig) begin
      // run along the top or bottom row
      d_ymode = WM_ONE;
      d_r0    = yneg ? RX'(0) : d_hlast;
      d_xmode = xin_c ? WM_CUB : WM_LIN;
      d_rsel  = xin_c ? RS_CUB1 : RS_LIN;
      if (xin_c) d_c0 = CX'(xi) - CX'(1);
    end else if (xin_c && yin_c) begin
      d_ymode = WM_CUB;
      d_xmode = WM_CUB;
      d_rsel  = RS_CUB2;
      d_r0 = RX'(yi) - RX'(1);
      d_c0 = CX'(xi) - CX'(1);
    end else begin
      d_ymode = WM_LIN;
      d_xmode = WM_LIN;
      d_rsel  = RS_BIL;
    end
  end

  function automatic logic signed [WW-1:0] axis_weight(
    input wmode_t m, input logic [F-1:0] a, input logic [2*F-1:0] a2,
    input logic [3*F-1:0] a3, input logic [1:0] idx);
    logic signed [WW-1:0] sa, sa2, sa3, one, r;
    sa  = WW'(a);
    sa2 = WW'(a2);
    sa3 = WW'(a3);
    one = WW'(1) <<< F;
    r   = '0;
    unique case (m)
      WM_ONE: r = (idx == 2'd0) ? WW'(1) : '0;
      WM_LIN: begin
        if (idx == 2'd0) r = one - sa;
        else if (idx == 2'd1) r = sa;
      end
      WM_CUB: begin
        unique case (idx)
          2'd0: r = -(sa <<< (2 * F)) + (sa2 <<< (F + 1)) - sa3;
          2'd1: r = (WW'(1) <<< (3 * F + 1)) - WW'(5) * (sa2 <<< F) + WW'(3) * sa3;
          2'd2: r = (sa <<< (2 * F)) + (sa2 <<< (F + 2)) - WW'(3) * sa3;
          2'd3: r = sa3 - (sa2 <<< F);
          default: r = '0;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // tap address, with the i+1 tap held at the last row or column
  logic [RX-1:0] trow;
  logic [CX-1:0] tcol;
  logic          last_tap;
  always_comb begin
    trow = r0 + RX'(tl);
    tcol = c0 + CX'(tk);
    if (trow > hlast) trow = hlast;
    if (tcol > wlast) tcol = wlast;
    last_tap = (tl == nl) && (tk == nk);
  end

  always_comb begin
    mem_we = 1'b0;
    if (busy) begin
      mem_addr = MAW'(32'(trow[RX-2:0]) * IMG_COLS + 32'(tcol[CX-2:0]));
    end else begin
      mem_addr = MAW'(32'(pixel_row) * IMG_COLS + 32'(pixel_column));
      mem_we = accept && (operation == OP_WRITE) && (32'(pixel_column) < IMG_COLS)
               && (32'(pixel_row) < IMG_ROWS);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= pixel_value;
    mem_rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // rounding (none for corner and bilinear) and clamp of the finished sum
  logic signed [ACW-1:0] rsum, rsh;
  logic [7:0]            rbyte;
  always_comb begin
    unique case (rsel)
      RS_CORNER: rsum = acc;
      RS_LIN:    rsum = acc + (ACW'(1) <<< (F - 1));
      RS_BIL:    rsum = acc;
      RS_CUB1:   rsum = acc + (ACW'(1) <<< (3 * F));
      RS_CUB2:   rsum = acc + (ACW'(1) <<< (6 * F + 1));
      default:   rsum = acc;
    endcase
    unique case (rsel)
      RS_CORNER: rsh = rsum;
      RS_LIN:    rsh = rsum >>> F;
      RS_BIL:    rsh = rsum >>> (2 * F);
      RS_CUB1:   rsh = rsum >>> (3 * F + 1);
      RS_CUB2:   rsh = rsum >>> (6 * F + 2);
      default:   rsh = rsum;
    endcase
    if (rsum < 0) rbyte = 8'd0;
    else if (rsh > ACW'(255)) rbyte = 8'd255;
    else rbyte = rsh[7:0];
  end

  function automatic logic [1:0] span(input wmode_t m);
    logic [1:0] r;
    unique case (m)
      WM_ONE:  r = 2'd0;
      WM_LIN:  r = 2'd1;
      WM_CUB:  r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // sequencer: setup weights, issue one tap a cycle, drain the MAC tail
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      v0    <= 1'b0;
      v1    <= 1'b0;
    end else begin
      done <= 1'b0;
      v0   <= (state == S_RUN);
      v1   <= v0;
      unique case (state)
        S_IDLE: begin
          if (accept && operation == OP_SAMPLE) begin
            state <= S_SQ;
            ymode <= d_ymode;
            xmode <= d_xmode;
            rsel  <= d_rsel;
            r0    <= d_r0;
            c0    <= d_c0;
            hlast <= d_hlast;
            wlast <= d_wlast;
            fa    <= y_pos[F-1:0];
            fb    <= x_pos[F-1:0];
            nl    <= span(d_ymode);
            nk    <= span(d_xmode);
          end
        end
        S_SQ: begin
          a2y   <= fa * fa;
          a2x   <= fb * fb;
          state <= S_CUBE;
        end
        S_CUBE: begin
          a3y   <= a2y * fa;
          a3x   <= a2x * fb;
          state <= S_WGT;
        end
        S_WGT: begin
          for (int n = 0; n < 4; n++) begin
            yw[n] <= axis_weight(ymode, fa, a2y, a3y, 2'(n));
            xw[n] <= axis_weight(xmode, fb, a2x, a3x, 2'(n));
          end
          tl    <= 2'd0;
          tk    <= 2'd0;
          state <= S_RUN;
        end
        S_RUN: begin
          // advance column first, then row
          if (last_tap) begin
            state <= S_DRAIN;
          end else if (tk == nk) begin
            tk <= 2'd0;
            tl <= tl + 2'd1;
          end else begin
            tk <= tk + 2'd1;
          end
        end
        S_DRAIN: begin
          if (!v0 && !v1) begin
            done         <= 1'b1;
            sample_value <= rbyte;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // MAC pipeline: weight product, times pixel, accumulate
  always_ff @(posedge clk) begin
    if (state == S_RUN) wprod <= yw[tl] * xw[tk];
    if (v0) prod <= wprod * $signed({1'b0, mem_rdata});
    if (state == S_WGT) acc <= '0;
    else if (v1) acc <= acc + ACW'(prod);
  end

endmodule
